// ===== sv/cba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_pkg: shared definitions for the contiguous bitmap allocator
// Sizes of the block map, sector geometry, status codes and the structs
// that pass between the sequencer, the map store and the word scanner.
// ----------------------------------------------------------------------------
package cba_pkg;

    localparam int NUM_BLOCKS   = 8192;
    localparam int SECTOR_BITS  = 4096;
    localparam int WORD_BITS    = 32;
    localparam int NUM_WORDS    = NUM_BLOCKS / WORD_BITS;
    localparam int WADDR_W      = $clog2(NUM_WORDS);
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int BLK_W        = 13;
    localparam int LEN_W        = 13;
    localparam int LIMIT_W      = 14;
    localparam int STATUS_W     = 2;
    localparam int RUN_W        = LEN_W + 1;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BITS);
    // Sectors are a whole number of map words, so a sector starts where the
    // low bits of the word index are zero.
    localparam int SEC_WSHIFT   = SECTOR_SHIFT - BIT_W;

    // Request opcodes as carried on the opcode port.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [WADDR_W-1:0]   waddr_t;
    typedef logic [BIT_W-1:0]     bitpos_t;
    typedef logic [LEN_W-1:0]     len_t;

    // One access of the map store.
    typedef struct packed {
        logic   rd_en;
        waddr_t rd_addr;
        logic   wr_en;
        waddr_t wr_addr;
        word_t  wr_data;
    } map_req_t;

    // Outcome of scanning one map word for a free run.
    typedef struct packed {
        logic    hit;
        bitpos_t pos;
        len_t    carry;
    } scan_res_t;

endpackage

// ===== sv/cba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/cba_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_map: usage bitmap store
// Holds the used/free bits in a word RAM. A valid bit per word makes every
// word read as all free until it is first written, so reset needs no sweep.
// ----------------------------------------------------------------------------
module cba_map (
    input  logic              clk,
    input  logic              rst_n,
    input  cba_pkg::map_req_t req,
    output cba_pkg::word_t    rd_data
);

    logic [cba_pkg::NUM_WORDS-1:0] row_vld_reg;
    logic                          rd_vld_reg;
    cba_pkg::word_t                ram_q;

    cba_ram #(
        .WIDTH (cba_pkg::WORD_BITS),
        .DEPTH (cba_pkg::NUM_WORDS)
    ) u_ram (
        .clk     (clk),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (ram_q),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                row_vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= row_vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = ram_q & {cba_pkg::WORD_BITS{rd_vld_reg}};

endmodule

// ===== sv/cba_word_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_word_scan: free-run finder for one map word
// Given the used bits of a word and the free run carried in from the words
// below, finds the lowest bit at which the run reaches the wanted length.
// ----------------------------------------------------------------------------
module cba_word_scan (
    input  cba_pkg::word_t     used,
    input  cba_pkg::len_t      carry_in,
    input  cba_pkg::len_t      len,
    output cba_pkg::scan_res_t res
);

    logic [cba_pkg::RUN_W-1:0] runlen [cba_pkg::WORD_BITS];

    // Free run ending at each bit: distance to the nearest used bit at or
    // below it, or the carried run plus the whole prefix when there is none.
    always_comb
    begin
        logic             has_used;
        cba_pkg::bitpos_t used_pos;
        for (int p = 0; p < cba_pkg::WORD_BITS; p++)
        begin
            has_used = 1'b0;
            used_pos = '0;
            for (int q = 0; q < cba_pkg::WORD_BITS; q++)
            begin
                if (q <= p && used[q])
                begin
                    has_used = 1'b1;
                    used_pos = cba_pkg::BIT_W'(q);
                end
            end
            if (has_used)
            begin
                runlen[p] = cba_pkg::RUN_W'(p) - cba_pkg::RUN_W'(used_pos);
            end
            else
            begin
                runlen[p] = cba_pkg::RUN_W'(carry_in) + cba_pkg::RUN_W'(p) +
                            cba_pkg::RUN_W'(1);
            end
        end
    end

    always_comb
    begin
        res.hit   = 1'b0;
        res.pos   = '0;
        res.carry = runlen[cba_pkg::WORD_BITS-1][cba_pkg::LEN_W-1:0];
        for (int p = cba_pkg::WORD_BITS - 1; p >= 0; p--)
        begin
            if (runlen[p] >= cba_pkg::RUN_W'(len))
            begin
                res.hit = 1'b1;
                res.pos = cba_pkg::BIT_W'(p);
            end
        end
    end

endmodule

// ===== sv/contiguous_bitmap_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_bitmap_allocator_unit: first-fit contiguous block allocator
// Keeps one used/free bit per block and serves allocate and free requests.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction on the input channel (in_valid/in_stall) carries an
// opcode, a first block and a run length. Each request yields exactly one
// response transaction on the output channel (out_valid/out_stall) with a
// status and, for a successful allocate, the start block of the run.
// Allocate scans the map one 32-bit word per cycle through the single read
// port of the map RAM and the word scanner, always from word 0, with reads
// one word ahead; a miss scans every map word, a hit ends the scan early
// and then reads and writes back each map word that the run touches. Free
// reads each touched word to check that all blocks are used, then reads
// and writes each one again to clear its blocks. A request rejected by its
// fields alone skips all map work. The response then waits in S_DONE
// until the output register is empty or being read, and moves into it.
// The block takes one request at a time: in_stall is high from acceptance
// until the response has been handed to the output register, which lets a
// new request come in while the previous response is still stalled.
// total_blocks is to be written through cfg_wr_en/cfg_wr_data only while
// idle; the block itself does not enforce this. Reset makes every block
// free at once (per-word valid bits), sets total_blocks to 8192 and
// empties the output register.
// ----------------------------------------------------------------------------
module contiguous_bitmap_allocator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [cba_pkg::LIMIT_W-1:0]   cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          opcode,
    input  logic [cba_pkg::BLK_W-1:0]     first_block,
    input  logic [cba_pkg::LEN_W-1:0]     run_length,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cba_pkg::STATUS_W-1:0]  status,
    output logic [cba_pkg::BLK_W-1:0]     run_start
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RMW_RD,
        S_RMW_WR,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        MODE_MARK,
        MODE_CHECK,
        MODE_CLEAR
    } mode_t;

    localparam int LWORD_W = cba_pkg::LIMIT_W - cba_pkg::BIT_W;

    // Registers.
    logic [cba_pkg::LIMIT_W-1:0]  total_blocks_reg;
    state_t                       state_reg, state_next;
    mode_t                        mode_reg, mode_next;
    logic [cba_pkg::WADDR_W:0]    issue_reg, issue_next;
    logic                         proc_vld_reg, proc_vld_next;
    cba_pkg::waddr_t              proc_word_reg, proc_word_next;
    cba_pkg::len_t                carry_reg, carry_next;
    cba_pkg::len_t                len_reg, len_next;
    logic [cba_pkg::BLK_W-1:0]    first_reg, first_next;
    logic [cba_pkg::BLK_W-1:0]    last_reg, last_next;
    cba_pkg::waddr_t              cur_word_reg, cur_word_next;
    logic [cba_pkg::STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [cba_pkg::BLK_W-1:0]    pend_start_reg, pend_start_next;
    logic                         out_valid_reg, out_valid_next;
    logic [cba_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [cba_pkg::BLK_W-1:0]    run_start_reg, run_start_next;

    // Datapath signals.
    logic [cba_pkg::LIMIT_W-1:0]  limit;
    logic [cba_pkg::LIMIT_W-1:0]  free_last;
    cba_pkg::map_req_t            map_req;
    cba_pkg::word_t               map_rd_data;
    cba_pkg::word_t               lim_mask;
    cba_pkg::word_t               scan_used;
    cba_pkg::len_t                scan_carry_in;
    cba_pkg::scan_res_t           scan_res;
    cba_pkg::word_t               run_mask;
    cba_pkg::waddr_t              first_word;
    cba_pkg::waddr_t              last_word;
    logic                         issuing;
    logic                         accept;
    logic [cba_pkg::BLK_W-1:0]    hit_end;
    logic [cba_pkg::BLK_W-1:0]    hit_start;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign run_start = run_start_reg;

    // Blocks at or above the managed limit are never touched.
    assign limit = (total_blocks_reg < cba_pkg::LIMIT_W'(cba_pkg::NUM_BLOCKS)) ?
                   total_blocks_reg : cba_pkg::LIMIT_W'(cba_pkg::NUM_BLOCKS);

    assign free_last = cba_pkg::LIMIT_W'(first_block) + cba_pkg::LIMIT_W'(run_length) -
                       cba_pkg::LIMIT_W'(1);

    assign first_word = first_reg[cba_pkg::BLK_W-1:cba_pkg::BIT_W];
    assign last_word  = last_reg[cba_pkg::BLK_W-1:cba_pkg::BIT_W];

    cba_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (map_req),
        .rd_data (map_rd_data)
    );

    // Bits of the word under scan that lie below the limit.
    always_comb
    begin
        for (int i = 0; i < cba_pkg::WORD_BITS; i++)
        begin
            if (LWORD_W'(proc_word_reg) < limit[cba_pkg::LIMIT_W-1:cba_pkg::BIT_W])
            begin
                lim_mask[i] = 1'b1;
            end
            else if (LWORD_W'(proc_word_reg) == limit[cba_pkg::LIMIT_W-1:cba_pkg::BIT_W])
            begin
                lim_mask[i] = (cba_pkg::BIT_W'(i) < limit[cba_pkg::BIT_W-1:0]);
            end
            else
            begin
                lim_mask[i] = 1'b0;
            end
        end
    end

    assign scan_used     = map_rd_data | ~lim_mask;
    // A run never continues across the start of a sector.
    assign scan_carry_in = (proc_word_reg[cba_pkg::SEC_WSHIFT-1:0] == '0) ? '0 : carry_reg;

    cba_word_scan u_scan (
        .used     (scan_used),
        .carry_in (scan_carry_in),
        .len      (len_reg),
        .res      (scan_res)
    );

    assign hit_end   = {proc_word_reg, scan_res.pos};
    assign hit_start = hit_end - cba_pkg::BLK_W'(len_reg) + cba_pkg::BLK_W'(1);

    // Bits of the current word that fall inside the run being marked,
    // checked or cleared.
    always_comb
    begin
        cba_pkg::bitpos_t lo;
        cba_pkg::bitpos_t hi;
        lo = (cur_word_reg == first_word) ? first_reg[cba_pkg::BIT_W-1:0] : '0;
        hi = (cur_word_reg == last_word) ? last_reg[cba_pkg::BIT_W-1:0] : '1;
        for (int i = 0; i < cba_pkg::WORD_BITS; i++)
        begin
            run_mask[i] = (cba_pkg::BIT_W'(i) >= lo) && (cba_pkg::BIT_W'(i) <= hi);
        end
    end

    assign issuing = (issue_reg < (cba_pkg::WADDR_W + 1)'(cba_pkg::NUM_WORDS));

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        issue_next       = issue_reg;
        proc_vld_next    = 1'b0;
        proc_word_next   = proc_word_reg;
        carry_next       = carry_reg;
        len_next         = len_reg;
        first_next       = first_reg;
        last_next        = last_reg;
        cur_word_next    = cur_word_reg;
        pend_status_next = pend_status_reg;
        pend_start_next  = pend_start_reg;
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        run_start_next   = run_start_reg;

        map_req.rd_en    = 1'b0;
        map_req.rd_addr  = cur_word_reg;
        map_req.wr_en    = 1'b0;
        map_req.wr_addr  = cur_word_reg;
        map_req.wr_data  = map_rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_start_next = '0;
                    if (run_length == '0)
                    begin
                        pend_status_next = cba_pkg::ST_INVALID;
                        state_next       = S_DONE;
                    end
                    else if (opcode == cba_pkg::OP_ALLOC)
                    begin
                        len_next   = run_length;
                        issue_next = '0;
                        carry_next = '0;
                        state_next = S_SCAN;
                    end
                    else if (free_last >= limit ||
                             first_block[cba_pkg::BLK_W-1:cba_pkg::SECTOR_SHIFT] !=
                             free_last[cba_pkg::BLK_W-1:cba_pkg::SECTOR_SHIFT])
                    begin
                        pend_status_next = cba_pkg::ST_INVALID;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        first_next       = first_block;
                        last_next        = free_last[cba_pkg::BLK_W-1:0];
                        cur_word_next    = first_block[cba_pkg::BLK_W-1:cba_pkg::BIT_W];
                        mode_next        = MODE_CHECK;
                        pend_status_next = cba_pkg::ST_OK;
                        state_next       = S_RMW_RD;
                    end
                end
            end

            S_SCAN:
            begin
                // Reads run one word ahead of the scanner.
                map_req.rd_en   = issuing;
                map_req.rd_addr = issue_reg[cba_pkg::WADDR_W-1:0];
                proc_vld_next   = issuing;
                proc_word_next  = issue_reg[cba_pkg::WADDR_W-1:0];
                if (issuing)
                begin
                    issue_next = issue_reg + (cba_pkg::WADDR_W + 1)'(1);
                end
                if (proc_vld_reg)
                begin
                    carry_next = scan_res.carry;
                    if (scan_res.hit)
                    begin
                        first_next       = hit_start;
                        last_next        = hit_end;
                        cur_word_next    = hit_start[cba_pkg::BLK_W-1:cba_pkg::BIT_W];
                        mode_next        = MODE_MARK;
                        pend_status_next = cba_pkg::ST_OK;
                        pend_start_next  = hit_start;
                        state_next       = S_RMW_RD;
                    end
                    else if (proc_word_reg == cba_pkg::WADDR_W'(cba_pkg::NUM_WORDS - 1))
                    begin
                        pend_status_next = cba_pkg::ST_NOSPACE;
                        state_next       = S_DONE;
                    end
                end
            end

            S_RMW_RD:
            begin
                map_req.rd_en = 1'b1;
                state_next    = S_RMW_WR;
            end

            S_RMW_WR:
            begin
                case (mode_reg)
                    MODE_CHECK:
                    begin
                        if ((map_rd_data & run_mask) != run_mask)
                        begin
                            pend_status_next = cba_pkg::ST_INVALID;
                            state_next       = S_DONE;
                        end
                        else if (cur_word_reg == last_word)
                        begin
                            mode_next     = MODE_CLEAR;
                            cur_word_next = first_word;
                            state_next    = S_RMW_RD;
                        end
                        else
                        begin
                            cur_word_next = cur_word_reg + cba_pkg::WADDR_W'(1);
                            state_next    = S_RMW_RD;
                        end
                    end
                    default:
                    begin
                        map_req.wr_en   = 1'b1;
                        map_req.wr_data = (mode_reg == MODE_MARK) ?
                                          (map_rd_data | run_mask) :
                                          (map_rd_data & ~run_mask);
                        if (cur_word_reg == last_word)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cur_word_next = cur_word_reg + cba_pkg::WADDR_W'(1);
                            state_next    = S_RMW_RD;
                        end
                    end
                endcase
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = pend_status_reg;
                    run_start_next = pend_start_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_MARK;
            issue_reg     <= '0;
            proc_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            issue_reg     <= issue_next;
            proc_vld_reg  <= proc_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_word_reg   <= proc_word_next;
        carry_reg       <= carry_next;
        len_reg         <= len_next;
        first_reg       <= first_next;
        last_reg        <= last_next;
        cur_word_reg    <= cur_word_next;
        pend_status_reg <= pend_status_next;
        pend_start_reg  <= pend_start_next;
        status_reg      <= status_next;
        run_start_reg   <= run_start_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_blocks_reg <= cba_pkg::LIMIT_W'(cba_pkg::NUM_BLOCKS);
        end
        else if (cfg_wr_en)
        begin
            total_blocks_reg <= cfg_wr_data;
        end
    end

`ifndef SYNTHESIS
    // The map is only written in the write half of a read-modify-write step.
    assert property (@(posedge clk) disable iff (!rst_n)
        map_req.wr_en |-> (state_reg == S_RMW_WR))
        else $error("map write outside the read-modify-write step");

    // The scanner always sees the word read in the cycle before.
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_vld_reg |->
        (issue_reg == ((cba_pkg::WADDR_W + 1)'(proc_word_reg) + (cba_pkg::WADDR_W + 1)'(1))))
        else $error("scan read pipeline out of step");

    // Run updates never leave the words spanned by the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RMW_RD || state_reg == S_RMW_WR) |->
        (cur_word_reg >= first_word && cur_word_reg <= last_word))
        else $error("run word pointer outside the run");

    // A finished request whose response can move is presented next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || !out_stall)) |=>
        (out_valid_reg && state_reg == S_IDLE))
        else $error("response not delivered to output register");

    // An accepted request always makes the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("request accepted without leaving idle");
`endif

endmodule

// ===== test/tb_contiguous_bitmap_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contiguous_bitmap_allocator_unit: self-checking bench for the allocator
// Drives allocate and free requests, tracks its own copy of the block map and
// of total_blocks, and compares every response with the predicted one.
// ----------------------------------------------------------------------------
module tb_contiguous_bitmap_allocator_unit;

    // Generous bound: roughly a thousand requests, each of which may scan the
    // whole map, with heavy stalling on both sides, taken several times over.
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [cba_pkg::STATUS_W-1:0] status;
        logic [cba_pkg::BLK_W-1:0]    run_start;
    } response_t;

    // A run that the bench believes to be allocated.
    typedef struct {
        int first;
        int count;
    } block_run_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wr_en;
    logic [cba_pkg::LIMIT_W-1:0]  cfg_wr_data;
    logic                         in_valid;
    logic                         in_stall;
    logic                         opcode;
    logic [cba_pkg::BLK_W-1:0]    first_block;
    logic [cba_pkg::LEN_W-1:0]    run_length;
    logic                         out_valid;
    logic                         out_stall;
    logic [cba_pkg::STATUS_W-1:0] status;
    logic [cba_pkg::BLK_W-1:0]    run_start;

    // Shadow of the block map and of the single configuration register.
    bit                           block_used [cba_pkg::NUM_BLOCKS];
    logic [cba_pkg::LIMIT_W-1:0]  total_blocks_shadow = 14'd8192;

    // Responses predicted at request acceptance, oldest first.
    response_t                    pending_responses [$];
    block_run_t                   live_runs [$];
    block_run_t                   last_freed = '{0, 1};

    int                           send_idle_pct  = 0;
    int                           recv_stall_pct = 0;
    logic                         out_hold;
    int                           error_count    = 0;
    int                           requests_sent  = 0;
    int                           count_ok       = 0;
    int                           count_nospace  = 0;
    int                           count_invalid  = 0;
    int                           cycle_count    = 0;

    contiguous_bitmap_allocator_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .first_block (first_block),
        .run_length  (run_length),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .run_start   (run_start)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // Prediction. Applies one request to the shadow map and returns the
    // response the block must give. Allocation is first fit, sector by
    // sector, and never reaches blocks at or above the managed limit. A free
    // is all or nothing: it is rejected unless the whole run is in range,
    // inside one sector and fully used.
    // ------------------------------------------------------------------------
    function automatic void serve_request(
        input  logic                         op,
        input  logic [cba_pkg::BLK_W-1:0]    first,
        input  logic [cba_pkg::LEN_W-1:0]    count,
        output logic [cba_pkg::STATUS_W-1:0] st,
        output logic [cba_pkg::BLK_W-1:0]    start_blk
    );
        int limit;
        int base;
        int off;
        int run;
        int run_first;
        int last;
        int k;
        bit found;
        limit     = (total_blocks_shadow < cba_pkg::NUM_BLOCKS) ?
                    int'(total_blocks_shadow) : cba_pkg::NUM_BLOCKS;
        st        = cba_pkg::ST_INVALID;
        start_blk = '0;
        found     = 1'b0;
        run_first = 0;
        if (count == '0)
            return;
        if (op == cba_pkg::OP_ALLOC)
        begin
            st = cba_pkg::ST_NOSPACE;
            for (base = 0; base < limit && !found; base += cba_pkg::SECTOR_BITS)
            begin
                run = 0;
                for (off = 0; off < cba_pkg::SECTOR_BITS && base + off < limit && !found;
                     off++)
                begin
                    if (!block_used[base + off])
                    begin
                        if (run == 0)
                            run_first = base + off;
                        run++;
                        if (run == int'(count))
                            found = 1'b1;
                    end
                    else
                    begin
                        run = 0;
                    end
                end
            end
            if (found)
            begin
                for (k = run_first; k < run_first + int'(count); k++)
                    block_used[k] = 1'b1;
                st        = cba_pkg::ST_OK;
                start_blk = run_first[cba_pkg::BLK_W-1:0];
            end
            return;
        end
        last = int'(first) + int'(count) - 1;
        if (last >= limit ||
            int'(first) / cba_pkg::SECTOR_BITS != last / cba_pkg::SECTOR_BITS)
            return;
        for (k = int'(first); k <= last; k++)
            if (!block_used[k])
                return;
        for (k = int'(first); k <= last; k++)
            block_used[k] = 1'b0;
        st = cba_pkg::ST_OK;
    endfunction

    // ------------------------------------------------------------------------
    // Request side. The task returns in the time step of the accepting edge
    // without touching in_valid, so the next call either raises it with a new
    // payload or drops it for an idle gap: one assignment per step either way.
    // ------------------------------------------------------------------------
    task automatic send_request(
        input  logic                         op,
        input  logic [cba_pkg::BLK_W-1:0]    first,
        input  logic [cba_pkg::LEN_W-1:0]    count,
        output logic [cba_pkg::STATUS_W-1:0] st,
        output logic [cba_pkg::BLK_W-1:0]    start_blk
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        first_block <= first;
        run_length  <= count;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        serve_request(op, first, count, st, start_blk);
        pending_responses.push_back('{st, start_blk});
        requests_sent++;
    endtask

    // Lets every outstanding transaction complete so the block is idle.
    task automatic drain_responses();
        in_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_total_blocks(input logic [cba_pkg::LIMIT_W-1:0] value);
        drain_responses();
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        total_blocks_shadow = value;
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Receiver: random stalls, or a solid hold-off while out_hold is set.
    always @(posedge clk)
    begin
        out_stall <= out_hold || ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Response checker. Every accepted response transaction is matched with
    // the oldest prediction, field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        response_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_responses.size() == 0)
            begin
                $display("%0t: unexpected response, status %0d run_start %0d",
                         $time, status, run_start);
                error_count++;
            end
            else
            begin
                want = pending_responses.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, status);
                    error_count++;
                end
                if (run_start !== want.run_start)
                begin
                    $display("%0t: run_start mismatch, expected %0d, actual %0d",
                             $time, want.run_start, run_start);
                    error_count++;
                end
                case (want.status)
                    cba_pkg::ST_OK:      count_ok++;
                    cba_pkg::ST_NOSPACE: count_nospace++;
                    default:             count_invalid++;
                endcase
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d responses outstanding",
                     $time, pending_responses.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed corner cases at the reset limit: zero lengths, a full map,
    // oversized allocations, sector crossing, runs past the end and double
    // frees, including one that overlaps used blocks and must clear nothing.
    // ------------------------------------------------------------------------
    task automatic test_directed_edges();
        logic [cba_pkg::STATUS_W-1:0] st;
        logic [cba_pkg::BLK_W-1:0]    s;
        send_request(cba_pkg::OP_ALLOC, 13'd0,    13'd0,    st, s);
        send_request(cba_pkg::OP_FREE,  13'd5,    13'd0,    st, s);
        send_request(cba_pkg::OP_ALLOC, 13'h1FFF, 13'd1,    st, s);
        send_request(cba_pkg::OP_ALLOC, 13'd0,    13'd4095, st, s);
        // Sector 0 is now full, so a whole sector can only go to sector 1.
        send_request(cba_pkg::OP_ALLOC, 13'd0,    13'd4096, st, s);
        send_request(cba_pkg::OP_ALLOC, 13'd0,    13'd1,    st, s);
        send_request(cba_pkg::OP_FREE,  13'd4095, 13'd2,    st, s);
        send_request(cba_pkg::OP_FREE,  13'd8191, 13'd1,    st, s);
        send_request(cba_pkg::OP_FREE,  13'd8191, 13'd1,    st, s);
        send_request(cba_pkg::OP_FREE,  13'd8190, 13'd2,    st, s);
        send_request(cba_pkg::OP_ALLOC, 13'd0,    13'd1,    st, s);
        send_request(cba_pkg::OP_ALLOC, 13'd0,    13'd4097, st, s);
        send_request(cba_pkg::OP_ALLOC, 13'd0,    13'h1FFF, st, s);
        send_request(cba_pkg::OP_FREE,  13'h1FFF, 13'h1FFF, st, s);
        send_request(cba_pkg::OP_FREE,  13'd0,    13'd4096, st, s);
        send_request(cba_pkg::OP_FREE,  13'd4096, 13'd4096, st, s);
        send_request(cba_pkg::OP_ALLOC, 13'd0,    13'd4096, st, s);
        send_request(cba_pkg::OP_FREE,  13'd0,    13'd4096, st, s);
    endtask

    // Limit of zero, a single managed block, and the widest register value.
    task automatic test_limit_extremes();
        logic [cba_pkg::STATUS_W-1:0] st;
        logic [cba_pkg::BLK_W-1:0]    s;
        write_total_blocks(14'd0);
        send_request(cba_pkg::OP_ALLOC, 13'd0, 13'd1, st, s);
        send_request(cba_pkg::OP_FREE,  13'd0, 13'd1, st, s);
        write_total_blocks(14'd1);
        send_request(cba_pkg::OP_ALLOC, 13'd0, 13'd1, st, s);
        send_request(cba_pkg::OP_ALLOC, 13'd0, 13'd1, st, s);
        send_request(cba_pkg::OP_FREE,  13'd0, 13'd2, st, s);
        send_request(cba_pkg::OP_FREE,  13'd0, 13'd1, st, s);
        write_total_blocks(14'h3FFF);
        send_request(cba_pkg::OP_ALLOC, 13'd0, 13'd8, st, s);
        send_request(cba_pkg::OP_FREE,  13'd0, 13'd8, st, s);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic. Mostly allocations of short runs and frees of runs the
    // bench knows to be allocated (whole, or a head or tail piece), plus some
    // noise: fully random fields, zero lengths and repeated frees.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic(input int items);
        logic [cba_pkg::STATUS_W-1:0] st;
        logic [cba_pkg::BLK_W-1:0]    s;
        logic [cba_pkg::BLK_W-1:0]    first;
        logic [cba_pkg::LEN_W-1:0]    count;
        block_run_t                   r;
        int                           i;
        int                           pick;
        int                           roll;
        int                           idx;
        int                           piece;
        bit                           head;
        for (i = 0; i < items; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                case ($urandom_range(3))
                    0: send_request(1'($urandom_range(1)), cba_pkg::BLK_W'($urandom),
                                    cba_pkg::LEN_W'($urandom), st, s);
                    1: send_request(1'($urandom_range(1)), cba_pkg::BLK_W'($urandom),
                                    13'd0, st, s);
                    2: send_request(cba_pkg::OP_FREE, last_freed.first[cba_pkg::BLK_W-1:0],
                                    last_freed.count[cba_pkg::LEN_W-1:0], st, s);
                    default: send_request(cba_pkg::OP_FREE, cba_pkg::BLK_W'($urandom),
                                          cba_pkg::LEN_W'($urandom_range(64, 1)), st, s);
                endcase
            end
            else if (live_runs.size() == 0 || (live_runs.size() < 48 && pick < 60))
            begin
                roll = $urandom_range(99);
                if (roll < 80)
                    count = cba_pkg::LEN_W'($urandom_range(64, 1));
                else if (roll < 95)
                    count = cba_pkg::LEN_W'($urandom_range(4096, 65));
                else
                    count = cba_pkg::LEN_W'($urandom_range(8191, 4097));
                // first_block is ignored for an allocate but still toggled.
                send_request(cba_pkg::OP_ALLOC, cba_pkg::BLK_W'($urandom), count, st, s);
                if (st == cba_pkg::ST_OK)
                    live_runs.push_back('{int'(s), int'(count)});
            end
            else
            begin
                idx   = $urandom_range(live_runs.size() - 1);
                r     = live_runs[idx];
                piece = (r.count > 1 && $urandom_range(2) != 0) ?
                        $urandom_range(r.count - 1, 1) : r.count;
                head  = 1'($urandom_range(1));
                first = head ? r.first[cba_pkg::BLK_W-1:0] :
                        cba_pkg::BLK_W'(r.first + r.count - piece);
                send_request(cba_pkg::OP_FREE, first, piece[cba_pkg::LEN_W-1:0], st, s);
                if (st == cba_pkg::ST_OK)
                begin
                    last_freed = '{int'(first), piece};
                    if (piece == r.count)
                    begin
                        live_runs.delete(idx);
                    end
                    else
                    begin
                        if (head)
                            r.first += piece;
                        r.count -= piece;
                        live_runs[idx] = r;
                    end
                end
            end
        end
    endtask

    // The receiver stalls solidly for a long stretch while requests keep
    // coming, so the output register fills and the block stalls its input.
    task automatic test_backpressure(input int items);
        fork
            begin
                out_hold <= 1'b1;
                repeat (600) @(posedge clk);
                out_hold <= 1'b0;
            end
            test_random_traffic(items);
        join
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        opcode      <= cba_pkg::OP_ALLOC;
        first_block <= '0;
        run_length  <= '0;
        out_hold    <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_limit_extremes();

        write_total_blocks(14'd8192);
        set_idling(0, 0);
        test_random_traffic(220);

        write_total_blocks(14'd37);
        set_idling(74, 0);
        test_random_traffic(140);

        write_total_blocks(14'd4097);
        set_idling(0, 74);
        test_random_traffic(200);

        write_total_blocks(14'd8191);
        set_idling(7, 7);
        test_random_traffic(250);

        write_total_blocks(14'h3FFF);
        set_idling(0, 0);
        test_backpressure(140);

        drain_responses();
        repeat (20) @(posedge clk);

        $display("Sent %0d requests across limits 0 to 16383 with idle and stall phases,",
                 requests_sent);
        $display("responses: %0d ok, %0d no space, %0d rejected; %0d errors",
                 count_ok, count_nospace, count_invalid, error_count);
        if (error_count == 0 && pending_responses.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
